[rtl/dlt_pkg.sv]
// Package for the DHCP lease table: widths, codes, sequencer states and
// the slot evaluation result type. No dependencies.
`timescale 1ns / 1ps

package dlt_pkg;

    localparam int MAX_POOL_DEF = 256;
    localparam int MAC_W        = 48;
    localparam int TIME_W       = 32;
    localparam int EXP_W        = 33;
    localparam int IP_W         = 32;
    localparam int CFG_W        = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int POOL_CNT_W   = 9;
    localparam logic [TIME_W-1:0] LEASE_TIME_RST = 32'd3600;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEASE_TIME = 2'd2;

    localparam logic REQ_DISCOVER = 1'b0;
    localparam logic REQ_REQUEST  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK,
        ST_EMPTY,
        ST_DUP,
        ST_UNKNOWN
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_DECIDE,
        S_ALLOC,
        S_DONE
    } state_t;

    typedef struct packed {
        logic expired;
        logic live;
        logic match;
    } slot_eval_t;

endpackage

[rtl/dlt_req_if.sv]
// Request channel interface of the DHCP lease table.
// Depends on dlt_pkg for field widths.
`timescale 1ns / 1ps

interface dlt_req_if
    import dlt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [MAC_W-1:0]  client_mac;
    logic [TIME_W-1:0] now_time;

    modport source (output valid, req_type, client_mac, now_time, input ready);
    modport sink   (input valid, req_type, client_mac, now_time, output ready);
endinterface

[rtl/dlt_rsp_if.sv]
// Response channel interface of the DHCP lease table.
// Depends on dlt_pkg for field widths.
`timescale 1ns / 1ps

interface dlt_rsp_if
    import dlt_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [1:0]      status;
    logic [IP_W-1:0] lease_ip;

    modport source (output valid, status, lease_ip, input ready);
    modport sink   (input valid, status, lease_ip, output ready);
endinterface

[rtl/dlt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/dlt_slot_eval.sv]
// Shared compare unit: judges one lease slot against the current time and
// the requested MAC. Depends on dlt_pkg.
`timescale 1ns / 1ps

module dlt_slot_eval
    import dlt_pkg::*;
(
    input  logic              slot_valid,
    input  logic [EXP_W-1:0]  slot_expiry,
    input  logic [MAC_W-1:0]  slot_mac,
    input  logic [MAC_W-1:0]  req_mac,
    input  logic [TIME_W-1:0] now_time,
    output slot_eval_t        result
);

    logic old;

    assign old            = slot_expiry < {1'b0, now_time};
    assign result.expired = slot_valid && old;
    assign result.live    = slot_valid && !old;
    assign result.match   = slot_valid && !old && (slot_mac == req_mac);

endmodule

[rtl/dhcp_lease_table.sv]
// DHCP lease table top level: sequencer, configuration registers and memories.
// Depends on dlt_pkg, dlt_req_if, dlt_rsp_if, dlt_ram and dlt_slot_eval.
//
// Usage: requests arrive on the req channel (valid/ready), one result per
// item leaves on the rsp channel. Configuration is a plain write port
// (cfg_we, cfg_idx, cfg_data); write only while the block is idle. Writing
// pool_count reloads the free stack and invalidates every lease at once.
// Each item makes one pass over all MAX_POOL slots through the shared slot
// compare unit, one slot per cycle, freeing expired leases and searching
// for the MAC and the lowest free slot at the same time. The slot memory's
// read is registered, and a decide state follows the pass. A discover that
// allocates then goes through an alloc state for the stack pop and slot
// write. One item is in work at a time: no new item is accepted until the
// last result has left the sequencer. The result sits in an output
// register; the next item is accepted while it waits. If the receiver
// stalls with a result still held, the next result waits in the sequencer.
// Reset empties the pool (pool_count 0), sets lease_time to 3600 and needs
// no clearing pass.
`timescale 1ns / 1ps

module dhcp_lease_table
    import dlt_pkg::*;
#(
    parameter int MAX_POOL = MAX_POOL_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data,
    dlt_req_if.sink              req,
    dlt_rsp_if.source            rsp
);

    localparam int IDX_W  = $clog2(MAX_POOL);
    localparam int CNT_W  = $clog2(MAX_POOL + 1);
    localparam int SLOT_W = MAC_W + IDX_W + EXP_W;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   free_cnt_reg, free_cnt_next;
    logic [MAX_POOL-1:0] slot_vld_reg, slot_vld_next;
    logic [MAX_POOL-1:0] stk_vld_reg, stk_vld_next;
    logic [IP_W-1:0]    pool_start_reg, pool_start_next;
    logic [TIME_W-1:0]  lease_time_reg, lease_time_next;
    logic               kind_reg, kind_next;
    logic [MAC_W-1:0]   mac_reg, mac_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   found_off_reg, found_off_next;
    logic               have_free_reg, have_free_next;
    logic [IDX_W-1:0]   free_slot_reg, free_slot_next;
    logic [IDX_W-1:0]   pop_idx_reg, pop_idx_next;
    status_t            res_status_reg, res_status_next;
    logic [IP_W-1:0]    res_ip_reg, res_ip_next;
    logic               out_vld_reg, out_vld_next;
    status_t            out_status_reg, out_status_next;
    logic [IP_W-1:0]    out_ip_reg, out_ip_next;

    logic               slot_we;
    logic [SLOT_W-1:0]  slot_wdata, slot_rdata;
    logic               stk_we;
    logic [IDX_W-1:0]   stk_waddr, stk_raddr, ev_idx, pop_off;
    logic [IDX_W-1:0]   stk_wdata, stk_rdata;
    logic [IDX_W-1:0]   rd_off;
    logic [EXP_W-1:0]   rd_exp;
    logic [MAC_W-1:0]   rd_mac;
    logic [CNT_W-1:0]   cfg_count;
    slot_eval_t         ev;

    assign rd_mac = slot_rdata[SLOT_W-1 -: MAC_W];
    assign rd_off = slot_rdata[EXP_W +: IDX_W];
    assign rd_exp = slot_rdata[EXP_W-1:0];
    assign ev_idx = IDX_W'(cnt_reg - 1'b1);
    assign stk_raddr = IDX_W'(free_cnt_reg - 1'b1);
    assign pop_off = stk_vld_reg[pop_idx_reg] ? stk_rdata : pop_idx_reg;
    assign cfg_count = (32'(cfg_data[POOL_CNT_W-1:0]) > 32'(MAX_POOL)) ?
                       CNT_W'(MAX_POOL) : CNT_W'(cfg_data[POOL_CNT_W-1:0]);

    dlt_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_POOL)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (free_slot_reg),
        .wdata (slot_wdata),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (slot_rdata)
    );

    dlt_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POOL)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    dlt_slot_eval u_eval (
        .slot_valid  (slot_vld_reg[ev_idx]),
        .slot_expiry (rd_exp),
        .slot_mac    (rd_mac),
        .req_mac     (mac_reg),
        .now_time    (now_reg),
        .result      (ev)
    );

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = out_vld_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.lease_ip = out_ip_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        free_cnt_next   = free_cnt_reg;
        slot_vld_next   = slot_vld_reg;
        stk_vld_next    = stk_vld_reg;
        pool_start_next = pool_start_reg;
        lease_time_next = lease_time_reg;
        kind_next       = kind_reg;
        mac_next        = mac_reg;
        now_next        = now_reg;
        found_next      = found_reg;
        found_off_next  = found_off_reg;
        have_free_next  = have_free_reg;
        free_slot_next  = free_slot_reg;
        pop_idx_next    = pop_idx_reg;
        res_status_next = res_status_reg;
        res_ip_next     = res_ip_reg;
        out_vld_next    = out_vld_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_ip_next     = out_ip_reg;
        slot_we         = 1'b0;
        slot_wdata      = {mac_reg, pop_off, {1'b0, now_reg} + {1'b0, lease_time_reg}};
        stk_we          = 1'b0;
        stk_waddr       = free_cnt_reg[IDX_W-1:0];
        stk_wdata       = rd_off;

        if (cfg_we)
        begin
            case (cfg_idx)
                CFG_POOL_START: pool_start_next = cfg_data;
                CFG_POOL_COUNT:
                begin
                    free_cnt_next = cfg_count;
                    slot_vld_next = '0;
                    stk_vld_next  = '0;
                end
                CFG_LEASE_TIME: lease_time_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next      = req.req_type;
                    mac_next       = req.client_mac;
                    now_next       = req.now_time;
                    cnt_next       = '0;
                    found_next     = 1'b0;
                    have_free_next = 1'b0;
                    state_next     = S_PASS;
                end
            end
            S_PASS:
            begin
                // Slot cnt-1 is judged while slot cnt is being read.
                if (cnt_reg != '0)
                begin
                    if (ev.expired)
                    begin
                        slot_vld_next[ev_idx] = 1'b0;
                        if (free_cnt_reg < CNT_W'(MAX_POOL))
                        begin
                            stk_we = 1'b1;
                            stk_vld_next[free_cnt_reg[IDX_W-1:0]] = 1'b1;
                            free_cnt_next = free_cnt_reg + 1'b1;
                        end
                    end
                    if (ev.match && !found_reg)
                    begin
                        found_next     = 1'b1;
                        found_off_next = rd_off;
                    end
                    if (!ev.live && !have_free_reg)
                    begin
                        have_free_next = 1'b1;
                        free_slot_next = ev_idx;
                    end
                end
                if (cnt_reg == CNT_W'(MAX_POOL))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DECIDE:
            begin
                res_ip_next = '0;
                state_next  = S_DONE;
                if (kind_reg == REQ_DISCOVER)
                begin
                    if (free_cnt_reg == '0)
                    begin
                        res_status_next = ST_EMPTY;
                    end
                    else if (found_reg)
                    begin
                        res_status_next = ST_DUP;
                    end
                    else if (!have_free_reg)
                    begin
                        res_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        pop_idx_next = stk_raddr;
                        state_next   = S_ALLOC;
                    end
                end
                else if (found_reg)
                begin
                    res_status_next = ST_OK;
                    res_ip_next     = pool_start_reg + IP_W'(found_off_reg);
                end
                else
                begin
                    res_status_next = ST_UNKNOWN;
                end
            end
            S_ALLOC:
            begin
                slot_we = 1'b1;
                slot_vld_next[free_slot_reg] = 1'b1;
                free_cnt_next   = free_cnt_reg - 1'b1;
                res_status_next = ST_OK;
                res_ip_next     = pool_start_reg + IP_W'(pop_off);
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_ip_next     = res_ip_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            free_cnt_reg   <= '0;
            slot_vld_reg   <= '0;
            stk_vld_reg    <= '0;
            pool_start_reg <= '0;
            lease_time_reg <= LEASE_TIME_RST;
            found_reg      <= 1'b0;
            have_free_reg  <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            free_cnt_reg   <= free_cnt_next;
            slot_vld_reg   <= slot_vld_next;
            stk_vld_reg    <= stk_vld_next;
            pool_start_reg <= pool_start_next;
            lease_time_reg <= lease_time_next;
            found_reg      <= found_next;
            have_free_reg  <= have_free_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        mac_reg        <= mac_next;
        now_reg        <= now_next;
        found_off_reg  <= found_off_next;
        free_slot_reg  <= free_slot_next;
        pop_idx_reg    <= pop_idx_next;
        res_status_reg <= res_status_next;
        res_ip_reg     <= res_ip_next;
        out_status_reg <= out_status_next;
        out_ip_reg     <= out_ip_next;
    end

endmodule
